@@ design/der_tlv_stream_parser_core_defines.svh @@
// assertion macros used by the checker file of the tlv parser
// no dependencies; include by bare file name
`ifndef DER_TLV_STREAM_PARSER_CORE_DEFINES_SVH
`define DER_TLV_STREAM_PARSER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DTSP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtsp assertion failed");

// next-cycle implication, disabled during reset
`define DTSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtsp assertion failed");

`endif

@@ design/dtsp_pkg.sv @@
// types and constants of the der tlv stream parser
// no dependencies
package dtsp_pkg;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
  localparam logic [7:0]  LEN_LONG_FORM = 8'h80;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_LEN_OCTETS = 3'd1;
  localparam logic [2:0] ERR_INDEFINITE = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd3;
  localparam logic [2:0] ERR_OVERRUN    = 3'd4;
  localparam logic [2:0] ERR_TOO_DEEP   = 3'd5;

  typedef enum logic [3:0] {
    PH_ID        = 4'b0001,
    PH_LEN_FIRST = 4'b0010,
    PH_LEN_MORE  = 4'b0100,
    PH_CONTENT   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [4:0]  tag_number;
    logic [31:0] content_length;
    logic [3:0]  depth;
    logic [7:0]  content_byte;
    logic [2:0]  error_code;
  } out_t;

  // parser state apart from the level stack
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  held_id;
    logic [31:0] len_acc;
    logic [3:0]  octets_left;
    logic [31:0] byte_offset;
    logic [31:0] prim_end;
    logic        err_latched;
  } st_t;

  localparam st_t ST_RESET = '{
    phase:       PH_ID,
    held_id:     8'd0,
    len_acc:     32'd0,
    octets_left: 4'd0,
    byte_offset: 32'd0,
    prim_end:    32'd0,
    err_latched: 1'b0
  };

endpackage

@@ design/dtsp_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module dtsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/dtsp_step.sv @@
// per-byte decode: next parser state, stack push and result for one byte
// depends on dtsp_pkg
module dtsp_step import dtsp_pkg::*; #(
  parameter int MAX_DEPTH     = 8,
  parameter int LENGTH_OCTETS = 4,
  localparam int LW = $clog2(MAX_DEPTH + 1)
) (
  input  in_t              item,
  input  st_t              st,
  input  logic [LW-1:0]    level,
  input  logic [31:0]      top_end,
  input  logic [LW-1:0]    top_pop,
  output st_t              st_next,
  output logic [LW-1:0]    level_next,
  output logic             push_en,
  output logic [31:0]      push_end,
  output logic [LW-1:0]    push_pop,
  output logic             res_en,
  output out_t             res
);

  localparam logic [LW-1:0] MAX_LVL = LW'(MAX_DEPTH);
  localparam logic [LW-1:0] ONE_LVL = LW'(1);
  localparam logic [6:0]    MAX_OCT = 7'(LENGTH_OCTETS);

  logic [7:0]    b;
  logic [31:0]   n;
  logic          open;
  logic          hdr_over;
  logic          done;
  logic          closing;
  logic          hdr;
  logic          cnt;
  logic [2:0]    err;
  logic [32:0]   end_sum;
  logic [31:0]   end_v;
  logic [31:0]   eff_end;
  logic [LW-1:0] eff_pop;

  assign b        = item.data_byte;
  assign n        = (st.byte_offset == SAT32) ? SAT32 : st.byte_offset + 32'd1;
  assign open     = (level != '0);
  assign hdr_over = open && (st.byte_offset >= top_end);

  always_comb begin
    st_next    = st;
    level_next = level;
    push_en    = 1'b0;
    push_end   = 32'd0;
    push_pop   = '0;
    res_en     = 1'b0;
    res        = '0;
    done       = 1'b0;
    closing    = 1'b0;
    hdr        = 1'b0;
    cnt        = 1'b0;
    err        = ERR_NONE;
    end_sum    = 33'd0;
    end_v      = 32'd0;
    eff_end    = 32'd0;
    eff_pop    = '0;

    if (st.err_latched) begin
      // skip until the final byte of the buffer
      if (item.last_byte) begin
        st_next    = ST_RESET;
        level_next = '0;
      end
    end else begin
      // header and content phases
      case (st.phase)
        PH_ID: begin
          if (hdr_over) begin
            err = ERR_OVERRUN;
          end else begin
            st_next.held_id = b;
            st_next.phase   = PH_LEN_FIRST;
          end
        end
        PH_LEN_FIRST: begin
          if (hdr_over) begin
            err = ERR_OVERRUN;
          end else if (b < LEN_LONG_FORM) begin
            st_next.len_acc = {24'd0, b};
            done = 1'b1;
          end else if (b == LEN_LONG_FORM) begin
            err = ERR_INDEFINITE;
          end else if (b[6:0] > MAX_OCT) begin
            err = ERR_LEN_OCTETS;
          end else begin
            st_next.len_acc     = 32'd0;
            st_next.octets_left = b[3:0];
            st_next.phase       = PH_LEN_MORE;
          end
        end
        PH_LEN_MORE: begin
          if (hdr_over) begin
            err = ERR_OVERRUN;
          end else begin
            if (st.len_acc[31:24] != 8'd0) begin
              st_next.len_acc = SAT32;
            end else begin
              st_next.len_acc = {st.len_acc[23:0], b};
            end
            if (st.octets_left != 4'd0) begin
              st_next.octets_left = st.octets_left - 4'd1;
            end
            if (st_next.octets_left == 4'd0) begin
              done = 1'b1;
            end
          end
        end
        PH_CONTENT: begin
          cnt = 1'b1;
          if (n >= st.prim_end) begin
            st_next.phase = PH_ID;
            closing = 1'b1;
          end
        end
        default: begin
          st_next.phase = PH_ID;
        end
      endcase

      // header complete: check bounds and depth, open the element
      if (done) begin
        end_sum = {1'b0, n} + {1'b0, st_next.len_acc};
        end_v   = end_sum[32] ? SAT32 : end_sum[31:0];
        if (open && (end_v > top_end)) begin
          err = ERR_OVERRUN;
        end else if (st_next.held_id[5] && (level >= MAX_LVL)) begin
          err = ERR_TOO_DEEP;
        end else begin
          hdr = 1'b1;
          st_next.phase = PH_ID;
          if (st_next.held_id[5]) begin
            push_en    = 1'b1;
            push_end   = end_v;
            // an end equal to the parent's joins the parent's closing run
            push_pop   = (open && (end_v == top_end)) ? top_pop : level;
            level_next = level + ONE_LVL;
            if (st_next.len_acc == 32'd0) begin
              closing = 1'b1;
            end
          end else if (st_next.len_acc == 32'd0) begin
            closing = 1'b1;
          end else begin
            st_next.prim_end = end_v;
            st_next.phase    = PH_CONTENT;
          end
        end
      end

      // close every level that ends here in one step
      eff_end = push_en ? push_end : top_end;
      eff_pop = push_en ? push_pop : top_pop;
      if (closing && (level_next != '0) && (eff_end <= n)) begin
        level_next = eff_pop;
      end

      st_next.byte_offset = n;

      if ((err == ERR_NONE) && item.last_byte &&
          ((st_next.phase != PH_ID) || (level_next != '0))) begin
        err = ERR_TRUNCATED;
      end

      // result item
      res.tag_class   = st_next.held_id[7:6];
      res.constructed = st_next.held_id[5];
      res.tag_number  = st_next.held_id[4:0];
      if (err != ERR_NONE) begin
        res_en         = 1'b1;
        res.kind       = KIND_ERROR;
        res.depth      = 4'(level_next);
        res.error_code = err;
      end else begin
        res_en             = hdr || cnt;
        res.kind           = hdr ? KIND_HEADER : KIND_CONTENT;
        res.content_length = st_next.len_acc;
        res.depth          = 4'(level);
        res.content_byte   = cnt ? b : 8'd0;
      end

      // end of buffer returns to top level
      if (item.last_byte) begin
        st_next    = ST_RESET;
        level_next = '0;
      end else if (err != ERR_NONE) begin
        st_next.err_latched = 1'b1;
      end
    end
  end

endmodule

@@ design/der_tlv_stream_parser_core.sv @@
// channel  | signals                          | payload
// byte     | byte_valid / byte_ready          | byte_item (in_t)
// result   | res_valid / res_ready            | res_item (out_t)
//
// One byte per cycle sustained; a byte's result passes the input register, the
// decode and then the result register before it is presented. The stack read
// is launched from the next level with the state update, so it adds no delay.
// Synchronous reset returns to top level; the end-offset stack needs no
// clearing, an entry is only read after it was pushed.
// A stalled result holds its register; one more byte waits in the input
// register before byte_ready drops.
//
// depends on dtsp_pkg, dtsp_step, dtsp_ram
module der_tlv_stream_parser_core import dtsp_pkg::*; #(
  parameter int MAX_DEPTH     = 8,
  parameter int LENGTH_OCTETS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic byte_valid,
  output logic byte_ready,
  input  in_t  byte_item,
  output logic res_valid,
  input  logic res_ready,
  output out_t res_item
);

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int EW = LW + 32;

  logic          inq_valid;
  in_t           inq_item;
  logic          step_go;
  st_t           st;
  st_t           st_next;
  logic [LW-1:0] level;
  logic [LW-1:0] level_next;
  logic [LW-1:0] level_sel;
  logic [LW-1:0] level_m1;
  logic          push_en;
  logic [31:0]   push_end;
  logic [LW-1:0] push_pop;
  logic          step_res_en;
  out_t          step_res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic          fwd;
  logic [EW-1:0] fwd_data;
  logic [EW-1:0] top_entry;

  assign step_go    = inq_valid && (!res_valid || res_ready);
  assign byte_ready = !inq_valid || step_go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (byte_ready) begin
      inq_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      inq_item <= byte_item;
    end
  end

  // top of the end-offset stack, with write forwarding
  assign top_entry = fwd ? fwd_data : ram_rdata;

  dtsp_step #(
    .MAX_DEPTH     (MAX_DEPTH),
    .LENGTH_OCTETS (LENGTH_OCTETS)
  ) u_step (
    .item       (inq_item),
    .st         (st),
    .level      (level),
    .top_end    (top_entry[31:0]),
    .top_pop    (top_entry[EW-1:32]),
    .st_next    (st_next),
    .level_next (level_next),
    .push_en    (push_en),
    .push_end   (push_end),
    .push_pop   (push_pop),
    .res_en     (step_res_en),
    .res        (step_res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_RESET;
      level <= '0;
    end else if (step_go) begin
      st    <= st_next;
      level <= level_next;
    end
  end

  // stack memory: read address follows the level of the next cycle
  assign level_sel = step_go ? level_next : level;
  assign level_m1  = level_sel - LW'(1);
  assign ram_raddr = level_m1[AW-1:0];
  assign ram_we    = step_go && push_en;
  assign ram_waddr = level[AW-1:0];
  assign ram_wdata = {push_pop, push_end};

  dtsp_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= ram_wdata;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step_go && step_res_en) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && step_res_en) begin
      res_item <= step_res;
    end
  end

endmodule

@@ design/dtsp_checker.sv @@
// port-level checks on the result channel of the tlv parser, bound to the top
// depends on dtsp_pkg and der_tlv_stream_parser_core_defines.svh
`include "der_tlv_stream_parser_core_defines.svh"

module dtsp_checker import dtsp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input out_t res_item
);

  // a stalled result request holds
  `DTSP_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_item))

  // error reports carry a code and no length or byte
  `DTSP_ASSERT_IMPL(a_err_fields, clk, rst, res_valid && (res_item.kind == KIND_ERROR), (res_item.error_code != ERR_NONE) && (res_item.content_length == 32'd0) && (res_item.content_byte == 8'd0))

  // headers and content bytes carry no error code
  `DTSP_ASSERT_IMPL(a_ok_no_code, clk, rst, res_valid && ((res_item.kind == KIND_HEADER) || (res_item.kind == KIND_CONTENT)), res_item.error_code == ERR_NONE)

  // content bytes only come from primitive elements
  `DTSP_ASSERT_IMPL(a_content_prim, clk, rst, res_valid && (res_item.kind == KIND_CONTENT), !res_item.constructed && (res_item.content_length != 32'd0))

endmodule

bind der_tlv_stream_parser_core dtsp_checker u_dtsp_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_item  (res_item)
);

@@ tb/der_tlv_stream_parser_checker.sv @@
// checker for der_tlv_stream_parser_core: watches both channels, predicts
// each result from the accepted bytes and compares it field by field
// depends on dtsp_pkg
`timescale 1ns / 1ps

module der_tlv_stream_parser_checker import dtsp_pkg::*; #(
  parameter int MAX_DEPTH     = 8,
  parameter int LENGTH_OCTETS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic byte_valid,
  input  logic byte_ready,
  input  in_t  byte_item,
  input  logic res_valid,
  input  logic res_ready,
  input  out_t res_item,
  output int   fail_count,
  output int   pending,
  output int   live_bytes
);

  // predicted parser state
  phase_t      walk_phase;
  logic [7:0]  walk_id;
  logic [31:0] walk_len;
  logic [3:0]  walk_octets;
  logic [31:0] walk_offset;
  logic [31:0] walk_ends [MAX_DEPTH];
  int          walk_level;
  logic [31:0] walk_prim_end;
  logic        walk_skipping;

  // results predicted but not yet seen
  out_t parsed_q [$];

  task automatic parser_reset();
    walk_phase    = PH_ID;
    walk_id       = 8'd0;
    walk_len      = 32'd0;
    walk_octets   = 4'd0;
    walk_offset   = 32'd0;
    walk_level    = 0;
    walk_prim_end = 32'd0;
    walk_skipping = 1'b0;
  endtask

  function automatic out_t pack_result(logic [1:0] kind, logic [31:0] len,
                                       logic [7:0] cbyte, logic [2:0] code);
    out_t r;
    r.kind           = kind;
    r.tag_class      = walk_id[7:6];
    r.constructed    = walk_id[5];
    r.tag_number     = walk_id[4:0];
    r.content_length = len;
    r.depth          = walk_level[3:0];
    r.content_byte   = cbyte;
    r.error_code     = code;
    return r;
  endfunction

  // one byte through the predicted parser
  task automatic decode_byte(input in_t it, output bit got, output out_t res);
    logic [7:0]  b;
    bit          last, in_open, done, closing, cons;
    logic [31:0] o, n, top, end_off;
    logic [32:0] sum;
    logic [39:0] shifted;
    logic [2:0]  code;
    int          cnt;
    b       = it.data_byte;
    last    = it.last_byte;
    o       = walk_offset;
    n       = (o == SAT32) ? SAT32 : o + 32'd1;
    in_open = walk_level > 0 && walk_level <= MAX_DEPTH;
    top     = in_open ? walk_ends[walk_level - 1] : 32'd0;
    code    = ERR_NONE;
    done    = 1'b0;
    closing = 1'b0;
    got     = 1'b0;
    res     = '0;

    // after an error everything up to the final byte is dropped
    if (walk_skipping) begin
      if (last) parser_reset();
      return;
    end

    case (walk_phase)
      PH_ID: begin
        if (in_open && o >= top) code = ERR_OVERRUN;
        else begin
          walk_id    = b;
          walk_phase = PH_LEN_FIRST;
        end
      end
      PH_LEN_FIRST: begin
        cnt = int'(b) - 128;
        if (in_open && o >= top) code = ERR_OVERRUN;
        else if (b < LEN_LONG_FORM) begin
          walk_len = {24'd0, b};
          done     = 1'b1;
        end else if (b == LEN_LONG_FORM) code = ERR_INDEFINITE;
        else if (cnt > LENGTH_OCTETS) code = ERR_LEN_OCTETS;
        else begin
          walk_len    = 32'd0;
          walk_octets = cnt[3:0];
          walk_phase  = PH_LEN_MORE;
        end
      end
      PH_LEN_MORE: begin
        if (in_open && o >= top) code = ERR_OVERRUN;
        else begin
          shifted  = {walk_len, b};
          walk_len = (shifted[39:32] != 8'd0) ? SAT32 : shifted[31:0];
          if (walk_octets > 0) walk_octets--;
          if (walk_octets == 0) done = 1'b1;
        end
      end
      PH_CONTENT: begin
        res = pack_result(KIND_CONTENT, walk_len, b, ERR_NONE);
        got = 1'b1;
        if (n >= walk_prim_end) begin
          walk_phase = PH_ID;
          closing    = 1'b1;
        end
      end
      default: walk_phase = PH_ID;
    endcase

    // header complete: check fit and depth, then open the element
    if (done) begin
      sum     = {1'b0, n} + {1'b0, walk_len};
      end_off = sum[32] ? SAT32 : sum[31:0];
      cons    = walk_id[5];
      if (in_open && end_off > top) code = ERR_OVERRUN;
      else if (cons && walk_level >= MAX_DEPTH) code = ERR_TOO_DEEP;
      else begin
        res        = pack_result(KIND_HEADER, walk_len, 8'd0, ERR_NONE);
        got        = 1'b1;
        walk_phase = PH_ID;
        if (cons) begin
          walk_ends[walk_level] = end_off;
          walk_level++;
          if (walk_len == 32'd0) closing = 1'b1;
        end else if (walk_len == 32'd0) closing = 1'b1;
        else begin
          walk_prim_end = end_off;
          walk_phase    = PH_CONTENT;
        end
      end
    end

    // pop every level that ends here
    if (closing) begin
      while (walk_level > 0 && walk_level <= MAX_DEPTH &&
             walk_ends[walk_level - 1] <= n)
        walk_level--;
    end

    walk_offset = n;

    if (code == ERR_NONE && last && (walk_phase != PH_ID || walk_level > 0))
      code = ERR_TRUNCATED;

    if (code != ERR_NONE) begin
      res = pack_result(KIND_ERROR, 32'd0, 8'd0, code);
      got = 1'b1;
      if (last) parser_reset();
      else walk_skipping = 1'b1;
      return;
    end
    if (last) parser_reset();
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, actual %0h", name, want, seen);
      fail_count++;
    end
  endtask

  // sample at the rising edge, compare first, then predict
  always @(posedge clk) begin
    out_t want, fresh;
    bit   got, was_skipping;
    if (rst) begin
      parser_reset();
      parsed_q.delete();
      fail_count = 0;
      live_bytes = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (parsed_q.size() == 0) begin
          $error("result with no request waiting for one");
          fail_count++;
        end else begin
          want = parsed_q.pop_front();
          compare_field("kind", 32'(want.kind), 32'(res_item.kind));
          compare_field("tag_class", 32'(want.tag_class), 32'(res_item.tag_class));
          compare_field("constructed", 32'(want.constructed), 32'(res_item.constructed));
          compare_field("tag_number", 32'(want.tag_number), 32'(res_item.tag_number));
          compare_field("content_length", want.content_length, res_item.content_length);
          compare_field("depth", 32'(want.depth), 32'(res_item.depth));
          compare_field("content_byte", 32'(want.content_byte),
                        32'(res_item.content_byte));
          compare_field("error_code", 32'(want.error_code), 32'(res_item.error_code));
        end
      end
      if (byte_valid && byte_ready) begin
        was_skipping = walk_skipping;
        decode_byte(byte_item, got, fresh);
        if (!was_skipping) live_bytes++;
        if (got) parsed_q.push_back(fresh);
      end
    end
    pending = parsed_q.size();
  end

endmodule

@@ tb/tb_der_tlv_stream_parser_core.sv @@
// top of the der tlv parser testbench: clock, reset, byte stimulus and verdict
// depends on dtsp_pkg, der_tlv_stream_parser_core, der_tlv_stream_parser_checker
`timescale 1ns / 1ps

module tb_der_tlv_stream_parser_core;
  import dtsp_pkg::*;

  typedef logic [7:0] octets_t [$];

  localparam int MAX_DEPTH     = 8;
  localparam int LENGTH_OCTETS = 4;
  localparam int LIVE_TARGET   = 750;
  localparam int CALM_FROM     = 640;

  logic clk;
  logic rst        = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_ready;
  in_t  byte_item  = '0;
  logic res_valid;
  logic res_ready  = 1'b0;
  out_t res_item;

  logic byte_took  = 1'b0;
  bit   calm       = 1'b0;
  int   ready_hold = 0;
  int   fail_count, pending, live_bytes;

  der_tlv_stream_parser_core #(
    .MAX_DEPTH     (MAX_DEPTH),
    .LENGTH_OCTETS (LENGTH_OCTETS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

  der_tlv_stream_parser_checker #(
    .MAX_DEPTH     (MAX_DEPTH),
    .LENGTH_OCTETS (LENGTH_OCTETS)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item),
    .fail_count (fail_count),
    .pending    (pending),
    .live_bytes (live_bytes)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // acceptance seen at the rising edge, read by the driver at the falling one
  always @(posedge clk) begin
    byte_took <= byte_valid && byte_ready && !rst;
  end

  // result side: random stall bursts between ready runs, always ready once calm
  always @(negedge clk) begin
    if (calm) res_ready <= 1'b1;
    else if (ready_hold > 0) ready_hold <= ready_hold - 1;
    else if ($urandom_range(0, 2) == 0) begin
      res_ready  <= 1'b0;
      ready_hold <= $urandom_range(1, 10) - 1;
    end else begin
      res_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 15);
    end
  end

  // length field in short form, or long form with optional leading zeros
  function automatic octets_t length_octets(int unsigned len);
    octets_t q;
    int      nb;
    if (len < 128 && $urandom_range(0, 3) != 0) begin
      q.push_back(len[7:0]);
      return q;
    end
    nb = (len > 32'hFF_FFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
    if (nb < LENGTH_OCTETS && $urandom_range(0, 3) == 0)
      nb = $urandom_range(nb, LENGTH_OCTETS);
    q.push_back(8'h80 | 8'(nb));
    for (int i = nb - 1; i >= 0; i--) q.push_back(8'(len >> (8 * i)));
    return q;
  endfunction

  // random element; chain_left forces a single-child constructed chain
  function automatic octets_t build_element(int lvl, int chain_left);
    octets_t     body, kid, whole;
    logic [7:0]  id;
    bit          cons;
    int          r, kids;
    int unsigned len;
    id = 8'($urandom);
    if (chain_left > 0) cons = 1'b1;
    else if (lvl < 3) cons = ($urandom_range(0, 9) < 4);
    else if (lvl < 6) cons = ($urandom_range(0, 9) < 2);
    else cons = 1'b0;
    id[5] = cons;
    if (chain_left > 0) begin
      kid = build_element(lvl + 1, chain_left - 1);
      foreach (kid[i]) body.push_back(kid[i]);
    end else if (cons) begin
      kids = $urandom_range(0, 3);
      repeat (kids) begin
        kid = build_element(lvl + 1, 0);
        foreach (kid[i]) body.push_back(kid[i]);
      end
    end else begin
      r = $urandom_range(0, 99);
      len = (r < 2) ? $urandom_range(128, 300) : $urandom_range(0, 6);
      repeat (len) body.push_back(8'($urandom));
    end
    whole.push_back(id);
    len = body.size();
    r = $urandom_range(0, 99);
    // mostly well formed; a few broken length fields and wrong lengths
    if (r == 0) whole.push_back(LEN_LONG_FORM);
    else if (r == 1) whole.push_back(8'h85 + 8'($urandom_range(0, 8'h7A)));
    else begin
      if (r < 4) len = len + $urandom_range(1, 2);
      else if (r < 6 && len > 0) len = len - 1;
      kid = length_octets(len);
      foreach (kid[i]) whole.push_back(kid[i]);
    end
    foreach (body[i]) whole.push_back(body[i]);
    return whole;
  endfunction

  // one request on the byte channel, with an occasional idle burst first
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_item  <= '{data_byte: b, last_byte: last};
    byte_valid <= 1'b1;
    do @(negedge clk); while (!byte_took);
  endtask

  task automatic send_buffer(input octets_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // stimulus and verdict
  initial begin
    octets_t stream_q, elem;
    int      sel, cut, waited;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty primitive, content byte, nesting, long form
    stream_q = {8'h05, 8'h00};
    send_buffer(stream_q);
    stream_q = {8'h04, 8'h01, 8'hAA};
    send_buffer(stream_q);
    stream_q = {8'h04, 8'h81, 8'h01, 8'hEE};
    send_buffer(stream_q);
    // several levels close on the same content byte
    stream_q = {8'h30, 8'h05, 8'h30, 8'h03, 8'h04, 8'h01, 8'h77};
    send_buffer(stream_q);
    // top-level siblings
    stream_q = {8'h02, 8'h01, 8'h05, 8'hE0, 8'h00};
    send_buffer(stream_q);
    // indefinite length, then skipped bytes
    stream_q = {8'h30, 8'h80, 8'h00};
    send_buffer(stream_q);
    // too many length octets
    stream_q = {8'h04, 8'h85, 8'hFF};
    send_buffer(stream_q);
    // truncated primitive
    stream_q = {8'h04, 8'h05, 8'h11};
    send_buffer(stream_q);
    // child longer than its parent
    stream_q = {8'h30, 8'h03, 8'h04, 8'h02, 8'h00};
    send_buffer(stream_q);
    // header byte past the parent end, error on the final byte
    stream_q = {8'h30, 8'h01, 8'h04, 8'h00};
    send_buffer(stream_q);
    // largest length, cut off by the final byte
    stream_q = {8'hDF, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buffer(stream_q);
    // nine nested constructed elements, one too many
    stream_q.delete();
    for (int k = 0; k < MAX_DEPTH + 1; k++) begin
      stream_q.push_back(8'h30);
      stream_q.push_back(8'(2 * (MAX_DEPTH - k)));
    end
    send_buffer(stream_q);

    // random buffers, mostly well formed trees
    while (live_bytes < LIVE_TARGET) begin
      if (live_bytes >= CALM_FROM) calm = 1'b1;
      sel = $urandom_range(0, 99);
      stream_q.delete();
      if (sel < 7) begin
        repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom));
      end else if (sel < 12) begin
        elem = build_element(0, $urandom_range(MAX_DEPTH - 2, MAX_DEPTH + 2));
        foreach (elem[i]) stream_q.push_back(elem[i]);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          elem = build_element(0, 0);
          foreach (elem[i]) stream_q.push_back(elem[i]);
        end
        if (sel < 22 && stream_q.size() > 1) begin
          cut = $urandom_range(1, (stream_q.size() > 4) ? 3 : stream_q.size() - 1);
          repeat (cut) void'(stream_q.pop_back());
        end else if (sel < 30) begin
          stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom);
        end
      end
      send_buffer(stream_q);
    end
    byte_valid <= 1'b0;

    // drain, then wait for stray results
    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (16) @(negedge clk);
    if (pending != 0) $error("results missing at end: %0d", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
